>>> design/gsdp_pkg.sv
// Shared types and constants for the group-scaled int8 dot product block.
package gsdp_pkg;

  // Configuration register map (word index = paddr / 4)
  localparam int          CFG_ADDR_W     = 4;
  localparam int          CFG_DATA_W     = 32;
  localparam logic [1:0]  REG_GROUP_SIZE = 2'd0;
  localparam logic [1:0]  REG_ROW_LENGTH = 2'd1;
  localparam logic [1:0]  REG_ROW_COUNT  = 2'd2;

  // Register field widths and reset values
  localparam int              GROUP_SIZE_W   = 9;
  localparam int              ROW_LENGTH_W   = 15;
  localparam int              ROW_COUNT_W    = 17;
  localparam logic [8:0]      GROUP_SIZE_RST = 9'd32;
  localparam logic [14:0]     ROW_LENGTH_RST = 15'd256;
  localparam logic [16:0]     ROW_COUNT_RST  = 17'd256;

  // Payload widths
  localparam int SCALE_W  = 24;
  localparam int GSUM_W   = 32;
  localparam int SPROD_W  = 32;
  localparam int RESULT_W = 64;
  localparam int INDEX_W  = 16;

  // Group queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // One closed group, handed from the front to the back
  typedef struct packed {
    logic [GSUM_W-1:0]  group_sum;
    logic [SCALE_W-1:0] weight_scale;
    logic [SCALE_W-1:0] activation_scale;
    logic               row_end;
    logic [INDEX_W-1:0] row_index;
    logic               last_row;
  } group_word_t;

endpackage

>>> design/gsdp_front.sv
// Front end: accepts element words, runs the int8 MAC and closes groups and rows.
module gsdp_front
  import gsdp_pkg::*;
#(
  parameter int MAX_GROUP      = 256,
  parameter int MAX_ROW_LENGTH = 16384,
  parameter int MAX_ROWS       = 65536
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [7:0]                     in_weight_value,
  input  logic signed [7:0]                     in_activation_value,
  input  logic [SCALE_W-1:0]                    in_weight_scale,
  input  logic [SCALE_W-1:0]                    in_activation_scale,
  input  logic [$clog2(MAX_GROUP+1)-1:0]        gsz,
  input  logic [$clog2(MAX_ROW_LENGTH+1)-1:0]   rlen,
  input  logic [$clog2(MAX_ROWS+1)-1:0]         rcnt,
  input  logic                                  q_full,
  output logic                                  push_valid,
  output group_word_t                           push_word
);

  localparam int GS_W  = $clog2(MAX_GROUP + 1);
  localparam int GP_W  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int RL_W  = $clog2(MAX_ROW_LENGTH + 1);
  localparam int RP_W  = $clog2(MAX_ROW_LENGTH);
  localparam int RCN_W = $clog2(MAX_ROWS + 1);
  localparam int RC_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [GP_W-1:0]   gpos_r;
  logic [RP_W-1:0]   rpos_r;
  logic [GSUM_W-1:0] gsum_r;
  logic [RC_W-1:0]   rctr_r;

  logic signed [15:0] prod;
  logic [GSUM_W-1:0]  gsum_new;
  logic               row_end;
  logic               group_end;
  logic               last;
  logic               accept;

  // Multiply, accumulate and find group and row boundaries
  always_comb begin
    prod      = in_weight_value * in_activation_value;
    gsum_new  = gsum_r + {{(GSUM_W-16){prod[15]}}, prod};
    row_end   = (RL_W'(rpos_r) + RL_W'(1)) >= rlen;
    group_end = row_end || ((GS_W'(gpos_r) + GS_W'(1)) >= gsz);
    last      = (RCN_W'(rctr_r) + RCN_W'(1)) >= rcnt;
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Hand a closed group to the queue
  assign push_valid                 = accept && group_end;
  assign push_word.group_sum        = gsum_new;
  assign push_word.weight_scale     = in_weight_scale;
  assign push_word.activation_scale = in_activation_scale;
  assign push_word.row_end          = row_end;
  assign push_word.row_index        = INDEX_W'(rctr_r);
  assign push_word.last_row         = last;

  // Advance positions and the row counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpos_r <= '0;
      rpos_r <= '0;
      gsum_r <= '0;
      rctr_r <= '0;
    end else if (accept) begin
      if (group_end) begin
        gpos_r <= '0;
        gsum_r <= '0;
      end else begin
        gpos_r <= gpos_r + GP_W'(1);
        gsum_r <= gsum_new;
      end
      if (row_end) begin
        rpos_r <= '0;
        rctr_r <= last ? '0 : rctr_r + RC_W'(1);
      end else begin
        rpos_r <= rpos_r + RP_W'(1);
      end
    end
  end

endmodule

>>> design/gsdp_queue.sv
// Short queue of closed groups between the front and the back.
module gsdp_queue
  import gsdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  input  group_word_t push_word,
  output logic        q_full,
  input  logic        pop,
  output logic        q_valid,
  output group_word_t head
);

  group_word_t      mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wptr_r;
  logic [Q_AW-1:0]  rptr_r;
  logic [Q_AW:0]    count_r;
  logic [Q_AW:0]    count_nxt;
  logic             do_pop;

  assign q_full  = count_r == (Q_AW+1)'(Q_DEPTH);
  assign q_valid = count_r != '0;
  assign head    = mem_r[rptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (push_valid && !do_pop) begin
      count_nxt = count_r + (Q_AW+1)'(1);
    end else if (!push_valid && do_pop) begin
      count_nxt = count_r - (Q_AW+1)'(1);
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wptr_r] <= push_word;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push_valid) begin
        wptr_r <= wptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + Q_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

>>> design/gsdp_back.sv
// Back end: scales each closed group and folds it into the saturating row sum.
module gsdp_back
  import gsdp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  group_word_t                head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [RESULT_W-1:0] out_row_result,
  output logic [INDEX_W-1:0]         out_row_index,
  output logic                       out_last_row
);

  // Stage A: scale product
  logic                a_valid_r;
  logic [GSUM_W-1:0]   a_gsum_r;
  logic [SPROD_W-1:0]  a_sp_r;
  logic                a_row_end_r;
  logic [INDEX_W-1:0]  a_idx_r;
  logic                a_last_r;
  // Stage B: group contribution
  logic                b_valid_r;
  logic [RESULT_W-1:0] b_contrib_r;
  logic                b_row_end_r;
  logic [INDEX_W-1:0]  b_idx_r;
  logic                b_last_r;
  // Stage C: row accumulator and output word
  logic [RESULT_W-1:0] row_sum_r;
  logic                out_valid_r;
  logic [RESULT_W-1:0] out_result_r;
  logic [INDEX_W-1:0]  out_idx_r;
  logic                out_last_r;

  logic                        adv;
  logic [2*SCALE_W-1:0]        sp_full;
  logic signed [SPROD_W:0]     sp_ext;
  logic signed [GSUM_W+SPROD_W:0] contrib_full;
  logic [RESULT_W-1:0]         sum_raw;
  logic [RESULT_W-1:0]         sum_sat;

  // Whole back end holds while a result waits to be taken
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && q_valid;

  always_comb begin
    sp_full      = (2*SCALE_W)'(head.weight_scale) * (2*SCALE_W)'(head.activation_scale);
    sp_ext       = {1'b0, a_sp_r};
    contrib_full = $signed(a_gsum_r) * sp_ext;
    sum_raw      = row_sum_r + b_contrib_r;
    sum_sat      = sum_raw;
    // Clamp on signed overflow
    if ((row_sum_r[RESULT_W-1] == b_contrib_r[RESULT_W-1]) &&
        (sum_raw[RESULT_W-1] != row_sum_r[RESULT_W-1])) begin
      sum_sat = row_sum_r[RESULT_W-1] ? {1'b1, {(RESULT_W-1){1'b0}}}
                                      : {1'b0, {(RESULT_W-1){1'b1}}};
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      a_gsum_r    <= head.group_sum;
      a_sp_r      <= sp_full[2*SCALE_W-1:16];
      a_row_end_r <= head.row_end;
      a_idx_r     <= head.row_index;
      a_last_r    <= head.last_row;
      b_contrib_r <= contrib_full[RESULT_W-1:0];
      b_row_end_r <= a_row_end_r;
      b_idx_r     <= a_idx_r;
      b_last_r    <= a_last_r;
      if (b_valid_r && b_row_end_r) begin
        out_result_r <= sum_sat;
        out_idx_r    <= b_idx_r;
        out_last_r   <= b_last_r;
      end
    end
  end

  // Pipeline control and row accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      row_sum_r   <= '0;
    end else if (adv) begin
      a_valid_r   <= q_valid;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r && b_row_end_r;
      if (b_valid_r) begin
        row_sum_r <= b_row_end_r ? '0 : sum_sat;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_result = out_result_r;
  assign out_row_index  = out_idx_r;
  assign out_last_row   = out_last_r;

endmodule

>>> design/group_scaled_int8_dot_product_top.sv
// Top level of the group-scaled int8 dot product block.
// Each input word carries one int8 weight, one int8 activation and the group's two Q4.20
// scales; the scales are used only on the word that closes a group. One output word per
// finished row: the saturated Q40.24 row sum, the row index within the pass and a last-row
// flag. The front end takes one input word per cycle as long as its four-entry group queue
// has room; the back end drains one closed group per cycle through three stages (scale
// product, group contribution, saturating row add); the word ending a row passes through
// the group queue and then these stages before its row result appears. A result held at
// the output stalls the back end, and the front end stalls once the group queue is full.
// Registers must be written only while the block is idle; the block does not enforce it.
module group_scaled_int8_dot_product_top
  import gsdp_pkg::*;
#(
  parameter int MAX_GROUP      = 256,
  parameter int MAX_ROW_LENGTH = 16384,
  parameter int MAX_ROWS       = 65536
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CFG_ADDR_W-1:0]      paddr,
  input  logic [CFG_DATA_W-1:0]      pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready,
  // input words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [7:0]          in_weight_value,
  input  logic signed [7:0]          in_activation_value,
  input  logic [SCALE_W-1:0]         in_weight_scale,
  input  logic [SCALE_W-1:0]         in_activation_scale,
  // result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [RESULT_W-1:0] out_row_result,
  output logic [INDEX_W-1:0]         out_row_index,
  output logic                       out_last_row
);

  localparam int GS_W  = $clog2(MAX_GROUP + 1);
  localparam int RL_W  = $clog2(MAX_ROW_LENGTH + 1);
  localparam int RCN_W = $clog2(MAX_ROWS + 1);
  localparam int GSC_W = (GS_W > GROUP_SIZE_W) ? GS_W : GROUP_SIZE_W;
  localparam int RLC_W = (RL_W > ROW_LENGTH_W) ? RL_W : ROW_LENGTH_W;
  localparam int RCC_W = (RCN_W > ROW_COUNT_W) ? RCN_W : ROW_COUNT_W;

  logic [GROUP_SIZE_W-1:0] group_size_r;
  logic [ROW_LENGTH_W-1:0] row_length_r;
  logic [ROW_COUNT_W-1:0]  row_count_r;

  logic                    cfg_wr;
  logic [GSC_W-1:0]        gs_ext;
  logic [RLC_W-1:0]        rl_ext;
  logic [RCC_W-1:0]        rc_ext;
  logic [GS_W-1:0]         gsz;
  logic [RL_W-1:0]         rlen;
  logic [RCN_W-1:0]        rcnt;

  logic                    q_full;
  logic                    push_valid;
  group_word_t             push_word;
  logic                    pop;
  logic                    q_valid;
  group_word_t             head;

  // Register write and read
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= GROUP_SIZE_RST;
      row_length_r <= ROW_LENGTH_RST;
      row_count_r  <= ROW_COUNT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_GROUP_SIZE: group_size_r <= pwdata[GROUP_SIZE_W-1:0];
        REG_ROW_LENGTH: row_length_r <= pwdata[ROW_LENGTH_W-1:0];
        REG_ROW_COUNT:  row_count_r  <= pwdata[ROW_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GROUP_SIZE: prdata = CFG_DATA_W'(group_size_r);
      REG_ROW_LENGTH: prdata = CFG_DATA_W'(row_length_r);
      REG_ROW_COUNT:  prdata = CFG_DATA_W'(row_count_r);
      default:        prdata = '0;
    endcase
  end

  // Clamp registers: zero acts as one, large values stop at the maximum
  always_comb begin
    gs_ext = GSC_W'(group_size_r);
    rl_ext = RLC_W'(row_length_r);
    rc_ext = RCC_W'(row_count_r);
    if (gs_ext == '0)                      gsz = GS_W'(1);
    else if (gs_ext > GSC_W'(MAX_GROUP))   gsz = GS_W'(MAX_GROUP);
    else                                   gsz = GS_W'(gs_ext);
    if (rl_ext == '0)                          rlen = RL_W'(1);
    else if (rl_ext > RLC_W'(MAX_ROW_LENGTH))  rlen = RL_W'(MAX_ROW_LENGTH);
    else                                       rlen = RL_W'(rl_ext);
    if (rc_ext == '0)                     rcnt = RCN_W'(1);
    else if (rc_ext > RCC_W'(MAX_ROWS))   rcnt = RCN_W'(MAX_ROWS);
    else                                  rcnt = RCN_W'(rc_ext);
  end

  gsdp_front #(
    .MAX_GROUP      (MAX_GROUP),
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .MAX_ROWS       (MAX_ROWS)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_weight_value     (in_weight_value),
    .in_activation_value (in_activation_value),
    .in_weight_scale     (in_weight_scale),
    .in_activation_scale (in_activation_scale),
    .gsz                 (gsz),
    .rlen                (rlen),
    .rcnt                (rcnt),
    .q_full              (q_full),
    .push_valid          (push_valid),
    .push_word           (push_word)
  );

  gsdp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_word  (push_word),
    .q_full     (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  gsdp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_result (out_row_result),
    .out_row_index  (out_row_index),
    .out_last_row   (out_last_row)
  );

endmodule

>>> sim/tb_group_scaled_int8_dot_product_top.sv
// Self-checking testbench for the group-scaled int8 dot product block.
`timescale 1ns / 100ps

module tb_group_scaled_int8_dot_product_top;
  import gsdp_pkg::*;

  localparam int          GROUP_CAP     = 256;
  localparam int          ROW_CAP       = 16384;
  localparam int          ROWS_CAP      = 65536;
  localparam logic [1:0]  REG_UNUSED    = 2'd3;
  localparam logic [23:0] SCALE_ONE     = 24'h100000;
  localparam logic [23:0] SCALE_MAX     = 24'hFFFFFF;
  localparam logic [63:0] SUM_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MIN       = 64'h8000_0000_0000_0000;
  localparam int          RANDOM_WORDS  = 600;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          STALL_LIMIT   = 1000;
  localparam int          REPORT_LIMIT  = 20;

  typedef struct packed {
    logic [RESULT_W-1:0] row_result;
    logic [INDEX_W-1:0]  row_index;
    logic                last_row;
  } row_word_t;

  // One line of the directed stimulus: a register write or an input word
  typedef struct packed {
    bit                 is_cfg;
    logic [1:0]         reg_idx;
    logic [31:0]        reg_val;
    logic [7:0]         weight;
    logic [7:0]         activation;
    logic [SCALE_W-1:0] wscale;
    logic [SCALE_W-1:0] ascale;
    bit                 typed;
    row_word_t          row;
  } plan_step_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]      paddr = '0;
  logic [CFG_DATA_W-1:0]      pwdata = '0;
  logic [CFG_DATA_W-1:0]      prdata;
  logic                       pready;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [7:0]          in_weight_value = '0;
  logic signed [7:0]          in_activation_value = '0;
  logic [SCALE_W-1:0]         in_weight_scale = '0;
  logic [SCALE_W-1:0]         in_activation_scale = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b1;
  logic signed [RESULT_W-1:0] out_row_result;
  logic [INDEX_W-1:0]         out_row_index;
  logic                       out_last_row;

  // Predictor copy of the registers and the accumulation state
  logic [GROUP_SIZE_W-1:0] cfg_group_size = GROUP_SIZE_RST;
  logic [ROW_LENGTH_W-1:0] cfg_row_length = ROW_LENGTH_RST;
  logic [ROW_COUNT_W-1:0]  cfg_row_count  = ROW_COUNT_RST;
  int unsigned             grp_pos = 0;
  int unsigned             row_pos = 0;
  logic [31:0]             grp_sum = '0;
  logic [63:0]             row_sum = '0;
  logic [INDEX_W-1:0]      row_ctr = '0;

  row_word_t pending_rows[$];
  row_word_t want;
  int        errors = 0;
  int        words_sent = 0;
  int        rows_checked = 0;
  int        reg_writes = 0;
  int        idle_cycles = 0;
  longint    cycles = 0;
  int        in_burst = 0;
  int        ready_left = 0;

  group_scaled_int8_dot_product_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_weight_value     (in_weight_value),
    .in_activation_value (in_activation_value),
    .in_weight_scale     (in_weight_scale),
    .in_activation_scale (in_activation_scale),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_row_result      (out_row_result),
    .out_row_index       (out_row_index),
    .out_last_row        (out_last_row)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Zero acts as one, anything above the cap is held at the cap
  function automatic int unsigned eff_size(int unsigned raw, int unsigned cap);
    if (raw == 0) return 1;
    if (raw > cap) return cap;
    return raw;
  endfunction

  // Fold one word into the group and row sums; return 1 when it closes a row
  function automatic bit accumulate_word(input logic signed [7:0] w,
                                         input logic signed [7:0] a,
                                         input logic [SCALE_W-1:0] wscale,
                                         input logic [SCALE_W-1:0] ascale,
                                         output row_word_t row);
    int unsigned        gsz;
    int unsigned        rlen;
    int unsigned        rcnt;
    logic signed [15:0] prod;
    logic [47:0]        scale_full;
    logic signed [63:0] sum64;
    logic signed [63:0] scale64;
    logic signed [63:0] contrib;
    logic [64:0]        total;
    bit                 row_end;
    bit                 last;
    gsz  = eff_size(cfg_group_size, GROUP_CAP);
    rlen = eff_size(cfg_row_length, ROW_CAP);
    rcnt = eff_size(cfg_row_count, ROWS_CAP);
    row  = '0;
    prod = w * a;
    grp_sum = grp_sum + {{16{prod[15]}}, prod};
    row_end = (row_pos + 1) >= rlen;

    // Close the group: scale product truncated to Q8.24, saturating row add
    if (row_end || (grp_pos + 1) >= gsz) begin
      scale_full = wscale * ascale;
      sum64      = $signed(grp_sum);
      scale64    = {32'd0, scale_full[47:16]};
      contrib    = sum64 * scale64;
      total      = {row_sum[63], row_sum} + {contrib[63], contrib};
      if (total[64] != total[63]) begin
        row_sum = total[64] ? SUM_MIN : SUM_MAX;
      end else begin
        row_sum = total[63:0];
      end
      grp_sum = '0;
      grp_pos = 0;
    end else begin
      grp_pos++;
    end

    if (!row_end) begin
      row_pos++;
      return 1'b0;
    end

    // Close the row and advance the row index, wrapping after the last row
    last = (32'(row_ctr) + 32'd1) >= rcnt;
    row.row_result = row_sum;
    row.row_index  = row_ctr;
    row.last_row   = last;
    row_sum = '0;
    row_pos = 0;
    row_ctr = last ? '0 : row_ctr + 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [31:0] reg_image(logic [1:0] idx);
    case (idx)
      REG_GROUP_SIZE: return 32'(cfg_group_size);
      REG_ROW_LENGTH: return 32'(cfg_row_length);
      REG_ROW_COUNT:  return 32'(cfg_row_count);
      default:        return '0;
    endcase
  endfunction

  // Mostly short pauses, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic int word_gap();
    if (in_burst > 0) begin
      in_burst--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      in_burst = $urandom_range(20, 80);
      return 0;
    end
    return ($urandom_range(0, 1) == 0) ? 0 : idle_len();
  endfunction

  function automatic logic [7:0] pick_int8();
    case ($urandom_range(0, 9))
      0:       return 8'h80;
      1:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SCALE_MAX;
      2:       return SCALE_ONE + SCALE_W'($urandom_range(0, 255)) - 24'd128;
      default: return SCALE_W'($urandom);
    endcase
  endfunction

  function automatic plan_step_t cfg_step(logic [1:0] idx, logic [31:0] value);
    plan_step_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = value;
    return s;
  endfunction

  function automatic plan_step_t word_step(logic [7:0] w, logic [7:0] a,
                                           logic [SCALE_W-1:0] ws, logic [SCALE_W-1:0] as_);
    plan_step_t s;
    s = '0;
    s.weight     = w;
    s.activation = a;
    s.wscale     = ws;
    s.ascale     = as_;
    return s;
  endfunction

  function automatic plan_step_t typed_step(logic [7:0] w, logic [7:0] a,
                                            logic [SCALE_W-1:0] ws, logic [SCALE_W-1:0] as_,
                                            logic [63:0] result, logic [15:0] index,
                                            logic last);
    plan_step_t s;
    s = word_step(w, a, ws, as_);
    s.typed = 1'b1;
    s.row   = '{result, index, last};
    return s;
  endfunction

  // One APB transfer: setup cycle, access cycle, then an idle cycle
  task automatic apb_cycle(bit write, logic [1:0] idx, logic [31:0] wdata,
                           output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(logic [1:0] idx);
    logic [31:0] got;
    apb_cycle(1'b0, idx, '0, got);
    if (got !== reg_image(idx)) begin
      if (errors < REPORT_LIMIT) begin
        $display("%0t: register %0d read expected %0h got %0h", $time, idx,
                 reg_image(idx), got);
      end
      errors++;
    end
  endtask

  task automatic check_all_regs();
    check_reg(REG_GROUP_SIZE);
    check_reg(REG_ROW_LENGTH);
    check_reg(REG_ROW_COUNT);
  endtask

  // Write a register, mirror it in the predictor and read it back
  task automatic program_reg(logic [1:0] idx, logic [31:0] value);
    logic [31:0] unused_rd;
    apb_cycle(1'b1, idx, value, unused_rd);
    reg_writes++;
    case (idx)
      REG_GROUP_SIZE: cfg_group_size = value[GROUP_SIZE_W-1:0];
      REG_ROW_LENGTH: cfg_row_length = value[ROW_LENGTH_W-1:0];
      REG_ROW_COUNT:  cfg_row_count  = value[ROW_COUNT_W-1:0];
      default: ;
    endcase
    if (idx == REG_UNUSED) begin
      check_all_regs();
    end else begin
      check_reg(idx);
    end
  endtask

  // Offer one word, hold it until taken, then predict and maybe pause
  task automatic send_word(logic [7:0] w, logic [7:0] a,
                           logic [SCALE_W-1:0] ws, logic [SCALE_W-1:0] as_,
                           bit typed, row_word_t typed_row);
    row_word_t predicted;
    int        gap;
    in_valid            <= 1'b1;
    in_weight_value     <= w;
    in_activation_value <= a;
    in_weight_scale     <= ws;
    in_activation_scale <= as_;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (accumulate_word(w, a, ws, as_, predicted)) begin
      pending_rows.push_back(typed ? typed_row : predicted);
    end
    words_sent++;
    gap = word_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_word(pick_int8(), pick_int8(), pick_scale(), pick_scale(), 1'b0, '0);
  endtask

  // Drop valid, wait for every row, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Randomize result backpressure: short runs and stalls, some long ready stretches
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_left <= idle_len() - 1;
    end else begin
      out_ready  <= 1'b1;
      ready_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 6);
    end
  end

  // Check each result word against the oldest expected row
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        if (errors < REPORT_LIMIT) begin
          $display("%0t: unexpected row: result %0d index %0d last %0b", $time,
                   out_row_result, out_row_index, out_last_row);
        end
        errors++;
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (out_row_result !== want.row_result) begin
          if (errors < REPORT_LIMIT) begin
            $display("%0t: row_result expected %0d got %0d", $time,
                     $signed(want.row_result), out_row_result);
          end
          errors++;
        end
        if (out_row_index !== want.row_index) begin
          if (errors < REPORT_LIMIT) begin
            $display("%0t: row_index expected %0d got %0d", $time, want.row_index,
                     out_row_index);
          end
          errors++;
        end
        if (out_last_row !== want.last_row) begin
          if (errors < REPORT_LIMIT) begin
            $display("%0t: last_row expected %0b got %0b", $time, want.last_row,
                     out_last_row);
          end
          errors++;
        end
      end
    end
  end

  // Count cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    cycles <= cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no handshake for %0d cycles, %0d rows still expected", $time,
             STALL_LIMIT, pending_rows.size());
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    plan_step_t  plan[$];
    int unsigned directed_words;
    int unsigned gs_raw;
    int unsigned rl_raw;
    int unsigned rc_raw;
    int unsigned rl_eff;
    int unsigned count;
    int          r;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_all_regs();

    // Single-element rows at unit, zero and full scales, extremes of both operands
    plan.push_back(cfg_step(REG_GROUP_SIZE, 32'd0));
    plan.push_back(cfg_step(REG_ROW_LENGTH, 32'd1));
    plan.push_back(cfg_step(REG_ROW_COUNT, 32'd2));
    plan.push_back(typed_step(8'h7F, 8'h7F, SCALE_ONE, SCALE_ONE,
                              64'h0000_003F_0100_0000, 16'd0, 1'b0));
    plan.push_back(typed_step(8'h80, 8'h80, SCALE_ONE, SCALE_ONE,
                              64'h0000_0040_0000_0000, 16'd1, 1'b1));
    plan.push_back(word_step(8'h80, 8'h7F, SCALE_MAX, SCALE_MAX));
    plan.push_back(typed_step(8'h00, 8'hFF, 24'd0, 24'd0, 64'd0, 16'd1, 1'b1));
    plan.push_back(typed_step(8'h7F, 8'h7F, 24'd0, SCALE_MAX, 64'd0, 16'd0, 1'b0));
    // Shrink the row count to no more than the current row index
    plan.push_back(cfg_step(REG_ROW_COUNT, 32'd1));
    plan.push_back(typed_step(8'hFF, 8'h01, SCALE_ONE, SCALE_ONE,
                              64'hFFFF_FFFF_FF00_0000, 16'd1, 1'b1));
    plan.push_back(word_step(8'h35, 8'hC2, 24'h0ABCDE, 24'hF01234));
    // Two full groups and a trailing partial group per row
    plan.push_back(cfg_step(REG_GROUP_SIZE, 32'd2));
    plan.push_back(cfg_step(REG_ROW_LENGTH, 32'd5));
    plan.push_back(cfg_step(REG_ROW_COUNT, 32'd3));
    plan.push_back(word_step(8'h03, 8'hF9, 24'h000001, 24'h000002));
    plan.push_back(word_step(8'h80, 8'h80, 24'h123456, 24'h654321));
    plan.push_back(word_step(8'h7F, 8'h80, 24'hFFFF00, 24'h00FFFF));
    plan.push_back(word_step(8'h7F, 8'h80, SCALE_MAX, SCALE_MAX));
    plan.push_back(word_step(8'h55, 8'hAA, 24'h0F0F0F, 24'hF0F0F0));
    // Group size above its cap: groups close at row end only
    plan.push_back(cfg_step(REG_GROUP_SIZE, 32'h1FF));
    plan.push_back(cfg_step(REG_ROW_LENGTH, 32'd3));
    plan.push_back(word_step(8'h80, 8'h7F, 24'h222222, 24'h333333));
    plan.push_back(word_step(8'h01, 8'h80, 24'h444444, 24'h555555));
    plan.push_back(word_step(8'hEE, 8'h11, 24'h800000, 24'h7FFFFF));
    // Stop mid-group, then shrink the group below the position reached and shorten the row
    plan.push_back(cfg_step(REG_GROUP_SIZE, 32'd4));
    plan.push_back(cfg_step(REG_ROW_LENGTH, 32'd8));
    plan.push_back(word_step(8'h12, 8'h34, 24'h111111, 24'h111111));
    plan.push_back(word_step(8'h80, 8'h7F, 24'h111111, 24'h111111));
    plan.push_back(word_step(8'h7F, 8'h7F, 24'h111111, 24'h111111));
    plan.push_back(cfg_step(REG_GROUP_SIZE, 32'd2));
    plan.push_back(cfg_step(REG_ROW_LENGTH, 32'd5));
    plan.push_back(word_step(8'h09, 8'hF7, 24'h0C0C0C, 24'h1A1A1A));
    plan.push_back(word_step(8'h66, 8'h99, 24'h3C3C3C, 24'hC3C3C3));
    plan.push_back(cfg_step(REG_UNUSED, 32'hFFFF_FFFF));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        program_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_word(plan[i].weight, plan[i].activation, plan[i].wscale, plan[i].ascale,
                  plan[i].typed, plan[i].row);
      end
    end
    directed_words = words_sent;

    // Random phases: mostly whole rows, some ending mid-row before a reconfiguration
    while (words_sent < directed_words + RANDOM_WORDS) begin
      settle();
      if ($urandom_range(0, 3) == 0) begin
        program_reg(REG_GROUP_SIZE, $urandom);
        program_reg(REG_ROW_LENGTH, $urandom);
        program_reg(REG_ROW_COUNT, $urandom);
      end
      r = $urandom_range(0, 9);
      gs_raw = (r == 0) ? 0 : (r == 1) ? $urandom_range(256, 511) : $urandom_range(1, 8);
      r = $urandom_range(0, 9);
      rl_raw = (r == 0) ? 0 : (r == 1) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      r = $urandom_range(0, 9);
      rc_raw = (r == 0) ? 0 : (r == 1) ? $urandom_range(6, 131071) : $urandom_range(1, 5);
      program_reg(REG_GROUP_SIZE, {23'($urandom), 9'(gs_raw)});
      program_reg(REG_ROW_LENGTH, {17'($urandom), 15'(rl_raw)});
      program_reg(REG_ROW_COUNT, {15'($urandom), 17'(rc_raw)});
      if ($urandom_range(0, 7) == 0) begin
        program_reg(REG_UNUSED, $urandom);
      end
      rl_eff = eff_size(rl_raw, ROW_CAP);
      count  = rl_eff * ((rl_eff > 24) ? 1 : $urandom_range(1, 4));
      if ($urandom_range(0, 3) == 0) begin
        count += $urandom_range(0, rl_eff - 1);
      end
      send_random(count);
    end

    settle();
    $display("summary: %0d input words, %0d rows checked, %0d register writes, %0d cycles",
             words_sent, rows_checked, reg_writes, cycles);
    $display("summary: rows of 1 to 200 elements, group sizes up to %0d and above the cap,",
             GROUP_CAP);
    $display("summary: zero and oversized registers, short passes, output stalls");
    if (errors == 0 && pending_rows.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
design/gsdp_pkg.sv
design/gsdp_front.sv
design/gsdp_queue.sv
design/gsdp_back.sv
design/group_scaled_int8_dot_product_top.sv
sim/tb_group_scaled_int8_dot_product_top.sv
